@@ rtl/core/assert_macros.svh @@
// assertion helper macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/core/dma_ctl_pkg.sv @@
// ----------------------------------------------------------------------------
// dma_ctl_pkg
// shared types and constants of the dma controller
// ----------------------------------------------------------------------------
`default_nettype none
package dma_ctl_pkg;
	localparam int unsigned DefChannelCount = 7;

	typedef enum logic [1:0] {
		CMD_REG_READ  = 2'd0,
		CMD_REG_WRITE = 2'd1,
		CMD_MEM_DATA  = 2'd2,
		CMD_TICK      = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_REG_DATA  = 2'd0,
		KIND_MEM_READ  = 2'd1,
		KIND_MEM_WRITE = 2'd2,
		KIND_UNUSED    = 2'd3
	} kind_t;

	localparam logic [2:0]  GpuChan   = 3'd2;
	localparam logic [2:0]  OtcChan   = 3'd6;
	localparam logic [31:0] GpuPort   = 32'h1F80_1810;
	localparam logic [23:0] EndMark   = 24'hFF_FFFF;
	localparam logic [6:0]  OffPrio   = 7'h70;
	localparam logic [6:0]  OffIrq    = 7'h74;
	localparam logic [3:0]  SubBase   = 4'h0;
	localparam logic [3:0]  SubCount  = 4'h4;
	localparam logic [3:0]  SubCtrl   = 4'h8;
	localparam int unsigned StartBit  = 24;

	typedef struct packed {
		logic [1:0]  command;
		logic [6:0]  reg_offset;
		logic [31:0] write_data;
		logic [31:0] mem_data;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] out_address;
		logic [31:0] out_data;
		logic        transfer_last;
		logic        engine_busy;
	} out_item_t;
endpackage
`default_nettype wire

@@ rtl/core/dma_ctl_if.sv @@
// ----------------------------------------------------------------------------
// dma_ctl_if
// valid/ready channel carrying one item type
// ----------------------------------------------------------------------------
`default_nettype none
interface dma_ctl_if #(parameter int unsigned W = 1);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/dma_ctl_queue.sv @@
// ----------------------------------------------------------------------------
// dma_ctl_queue
// two-entry queue between front and back
// ----------------------------------------------------------------------------
`default_nettype none
module dma_ctl_queue
	import dma_ctl_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_item_t push_item,
	output logic          full,
	input  wire logic     pop,
	output logic          not_empty,
	output in_item_t      head
);
	in_item_t   mem_q [2];
	logic       wptr_q;
	logic       rptr_q;
	logic [1:0] cnt_q;

	assign full      = cnt_q[1];
	assign not_empty = cnt_q != 2'd0;
	assign head      = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) wptr_q <= ~wptr_q;
			if (pop) rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/dma_ctl_engine.sv @@
// ----------------------------------------------------------------------------
// dma_ctl_engine
// register file and transfer engine, one item per cycle while not stalled
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module dma_ctl_engine
	import dma_ctl_pkg::*;
#(
	parameter int unsigned CHANNEL_COUNT = DefChannelCount
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      item_valid,
	input  wire in_item_t  item,
	output logic           item_take,
	dma_ctl_if.source      res
);
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HEAD = 2'd1,
		PH_LOAD = 2'd2,
		PH_FILL = 2'd3
	} phase_t;

	logic [31:0] base_q  [CHANNEL_COUNT];
	logic [31:0] count_q [CHANNEL_COUNT];
	logic [31:0] ctrl_q  [CHANNEL_COUNT];
	logic [31:0] prio_q, irq_q;
	phase_t      phase_q;
	logic [2:0]  chan_q;
	logic [31:0] walk_q;
	logic [7:0]  left_q;
	logic [23:0] next_q;
	logic        first_q, pend_q;
	logic        res_valid_q;
	out_item_t   res_q;

	logic [2:0]  ch;
	logic [3:0]  sub;
	logic        in_chan, act_ok;
	logic [31:0] act_ctrl, act_count, delta;
	logic [7:0]  left_dec;

	assign item_take = item_valid && (!res_valid_q || res.ready);
	assign res.valid = res_valid_q;
	assign res.data  = res_q;

	assign ch       = item.reg_offset[6:4];
	assign sub      = item.reg_offset[3:0];
	assign in_chan  = 32'(ch) < CHANNEL_COUNT;
	assign act_ok   = 32'(chan_q) < CHANNEL_COUNT;
	assign act_ctrl  = act_ok ? ctrl_q[chan_q[$clog2(CHANNEL_COUNT+1)-1:0]] : 32'd0;
	assign act_count = act_ok ? count_q[chan_q[$clog2(CHANNEL_COUNT+1)-1:0]] : 32'd0;
	assign delta    = act_ctrl[1] ? 32'hFFFF_FFFC : 32'd4;
	assign left_dec = left_q - 8'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		logic        emit;
		logic [31:0] rd, addr, data, cnt_new;
		logic        last, fin;
		phase_t      ph;
		if (!arst_n) begin
			for (int i = 0; i < CHANNEL_COUNT; i++) begin
				base_q[i]  <= '0;
				count_q[i] <= '0;
				ctrl_q[i]  <= '0;
			end
			prio_q      <= '0;
			irq_q       <= '0;
			phase_q     <= PH_IDLE;
			chan_q      <= '0;
			walk_q      <= '0;
			left_q      <= '0;
			next_q      <= '0;
			first_q     <= 1'b0;
			pend_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			emit = 1'b0;
			if (item_take) begin
				addr = '0;
				data = '0;
				last = 1'b0;
				fin  = 1'b0;
				ph   = phase_q;
				rd   = 32'hFFFF_FFFF;
				cnt_new = act_count;
				unique case (cmd_t'(item.command))
					CMD_REG_READ: begin
						if (in_chan) begin
							if (sub == SubBase) rd = base_q[ch];
							else if (sub == SubCount) rd = count_q[ch];
							else if (sub == SubCtrl) rd = ctrl_q[ch];
						end else if (item.reg_offset == OffPrio) rd = prio_q;
						else if (item.reg_offset == OffIrq) rd = irq_q;
						emit = 1'b1;
						data = rd;
					end
					CMD_REG_WRITE: begin
						if (in_chan) begin
							if (sub == SubBase) base_q[ch] <= item.write_data;
							else if (sub == SubCount) count_q[ch] <= item.write_data;
							else if (sub == SubCtrl) begin
								if (phase_q != PH_IDLE || !item.write_data[StartBit]) begin
									ctrl_q[ch] <= item.write_data & ~(32'd1 << StartBit);
								end else begin
									// start bit while idle: begin a gpu or ordering-table transfer, or stay idle
									chan_q <= ch;
									walk_q <= base_q[ch];
									pend_q <= 1'b0;
									if (item.write_data[10:9] == 2'd2 && item.write_data[0]
										&& ch == GpuChan
										&& base_q[ch][23:0] != EndMark) begin
										ctrl_q[ch] <= item.write_data;
										ph = PH_HEAD;
									end else if (item.write_data[10:9] == 2'd0
										&& !item.write_data[0] && ch == OtcChan) begin
										ctrl_q[ch] <= item.write_data;
										first_q <= 1'b1;
										ph = PH_FILL;
									end else begin
										ctrl_q[ch] <= item.write_data & ~(32'd1 << StartBit);
										ph = PH_IDLE;
										left_q <= '0;
										first_q <= 1'b0;
									end
								end
							end
						end else if (item.reg_offset == OffPrio) prio_q <= item.write_data;
						else if (item.reg_offset == OffIrq) irq_q <= item.write_data;
					end
					CMD_MEM_DATA: begin
						if (pend_q) begin
							pend_q <= 1'b0;
							if (phase_q == PH_HEAD) begin
								left_q <= item.mem_data[31:24];
								next_q <= item.mem_data[23:0];
								if (item.mem_data[31:24] != 8'd0) ph = PH_LOAD;
								else begin
									walk_q <= {8'd0, item.mem_data[23:0]};
									if (item.mem_data[23:0] == EndMark) fin = 1'b1;
								end
							end else if (phase_q == PH_LOAD) begin
								left_q <= left_dec;
								if (left_dec == 8'd0) begin
									walk_q <= {8'd0, next_q};
									if (next_q == EndMark) begin
										last = 1'b1;
										fin  = 1'b1;
									end else ph = PH_HEAD;
								end
								emit = 1'b1;
								addr = GpuPort;
								data = item.mem_data;
							end
						end
					end
					CMD_TICK: begin
						if (!pend_q) begin
							if (phase_q == PH_HEAD) begin
								pend_q <= 1'b1;
								emit = 1'b1;
								addr = walk_q;
							end else if (phase_q == PH_LOAD) begin
								pend_q <= 1'b1;
								walk_q <= walk_q + delta;
								emit = 1'b1;
								addr = walk_q + delta;
							end else if (phase_q == PH_FILL && act_ok) begin
								if (first_q) begin
									first_q <= 1'b0;
									addr = walk_q;
									data = {8'd0, EndMark};
								end else begin
									walk_q <= walk_q + delta;
									if (act_count != 32'd0) cnt_new = act_count - 32'd1;
									count_q[chan_q[$clog2(CHANNEL_COUNT+1)-1:0]] <= cnt_new;
									addr = walk_q + delta;
									data = {8'd0, walk_q[23:0]};
								end
								last = cnt_new == 32'd0;
								fin  = last;
								emit = 1'b1;
							end
						end
					end
					default: ;
				endcase
				// pending read, word count and first flag are already clear on every
				// path that finishes a transfer
				if (fin) begin
					if (act_ok) begin
						ctrl_q[chan_q[$clog2(CHANNEL_COUNT+1)-1:0]] <=
							act_ctrl & ~(32'd1 << StartBit);
					end
					ph = PH_IDLE;
				end
				phase_q <= ph;
				if (emit) begin
					res_q.kind <= (cmd_t'(item.command) == CMD_REG_READ) ? KIND_REG_DATA :
						(cmd_t'(item.command) == CMD_TICK && (phase_q == PH_HEAD
						|| phase_q == PH_LOAD)) ? KIND_MEM_READ : KIND_MEM_WRITE;
					res_q.out_address   <= addr;
					res_q.out_data      <= data;
					res_q.transfer_last <= last;
					res_q.engine_busy   <= ph != PH_IDLE;
				end
			end
			res_valid_q <= emit || (res_valid_q && !res.ready);
		end
	end

	`ASSERT_IMPLIES(a_last_idle, clk, arst_n, res_valid_q && res_q.transfer_last,
		!res_q.engine_busy)
	`ASSERT_IMPLIES(a_idle_no_pend, clk, arst_n, phase_q == PH_IDLE, !pend_q)
	`ASSERT_NEXT(a_hold, clk, arst_n, res_valid_q && !res.ready, res_valid_q)
endmodule
`default_nettype wire

@@ rtl/core/dma_controller_ot_and_linked_list.sv @@
// ----------------------------------------------------------------------------
// dma_controller_ot_and_linked_list
// seven-channel dma controller with linked-list and ordering-table engines
// ----------------------------------------------------------------------------
// usage
//   in  : one item per bus access, memory data return or memory slot tick
//   out : register read data, memory read requests and memory write requests
//   the front accepts items into a two-entry queue; the back engine takes
//   one item per cycle from the queue while its results are not stalled
//   and updates registers and walk state; an accepted item passes the
//   queue entry and then the engine's result register before its result
//   is valid; throughput: one item per cycle while the receiver does
//   not stall, as set by the engine's register and walk update
//   reset: queue pointers and all engine registers clear, engine goes idle
//   when the receiver stalls, the result register holds; the queue keeps
//   taking items until it is full, then ready drops
//   items that cause no result pass through without output
// ----------------------------------------------------------------------------
`default_nettype none
module dma_controller_ot_and_linked_list
	import dma_ctl_pkg::*;
#(
	parameter int unsigned CHANNEL_COUNT = DefChannelCount
) (
	input  wire logic clk,
	input  wire logic arst_n,
	dma_ctl_if.sink   in_ch,
	dma_ctl_if.source out_ch
);
	logic     q_full, q_ne, take;
	in_item_t q_head;

	// front: queue accepts while space remains
	assign in_ch.ready = !q_full;

	dma_ctl_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (in_ch.valid && !q_full),
		.push_item (in_ch.data),
		.full      (q_full),
		.pop       (take),
		.not_empty (q_ne),
		.head      (q_head)
	);

	// back: register file and transfer engine
	dma_ctl_engine #(.CHANNEL_COUNT(CHANNEL_COUNT)) u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (q_ne),
		.item       (q_head),
		.item_take  (take),
		.res        (out_ch)
	);
endmodule
`default_nettype wire
